/* hw/rtl/sts_pkg.sv */
// Shared constants, codes and the keyword decoder for the SQL token scanner.
// No dependencies; every other file of the block imports this package.
package sts_pkg;

  localparam int unsigned PosWidthDef = 16;  // default offset/length width
  localparam int unsigned FieldW      = 16;  // width of the start/length ports
  localparam int unsigned KindW       = 4;
  localparam int unsigned CodeW       = 4;
  localparam int unsigned QueueDepth  = 4;   // front-to-back queue entries

  // token kinds
  localparam logic [KindW-1:0] KIND_END     = 4'd0;
  localparam logic [KindW-1:0] KIND_KEYWORD = 4'd1;
  localparam logic [KindW-1:0] KIND_WORD    = 4'd2;
  localparam logic [KindW-1:0] KIND_NUMBER  = 4'd3;
  localparam logic [KindW-1:0] KIND_STRING  = 4'd4;
  localparam logic [KindW-1:0] KIND_COMMA   = 4'd5;
  localparam logic [KindW-1:0] KIND_SEMI    = 4'd6;
  localparam logic [KindW-1:0] KIND_LPAREN  = 4'd7;
  localparam logic [KindW-1:0] KIND_RPAREN  = 4'd8;
  localparam logic [KindW-1:0] KIND_STAR    = 4'd9;
  localparam logic [KindW-1:0] KIND_DOT     = 4'd10;
  localparam logic [KindW-1:0] KIND_UNKNOWN = 4'd11;
  localparam logic [KindW-1:0] KIND_UNTERM  = 4'd12;

  // keyword codes
  localparam logic [CodeW-1:0] KW_SELECT  = 4'd0;
  localparam logic [CodeW-1:0] KW_FROM    = 4'd1;
  localparam logic [CodeW-1:0] KW_WHERE   = 4'd2;
  localparam logic [CodeW-1:0] KW_AND     = 4'd3;
  localparam logic [CodeW-1:0] KW_OR      = 4'd4;
  localparam logic [CodeW-1:0] KW_ORDERBY = 4'd5;
  localparam logic [CodeW-1:0] KW_GROUPBY = 4'd6;
  localparam logic [CodeW-1:0] KW_ASC     = 4'd7;
  localparam logic [CodeW-1:0] KW_DESC    = 4'd8;
  localparam logic [CodeW-1:0] KW_LIMIT   = 4'd9;

  // characters
  localparam logic [7:0] CH_NUL    = 8'h00;
  localparam logic [7:0] CH_SPACE  = 8'h20;
  localparam logic [7:0] CH_QUOTE  = 8'h27;
  localparam logic [7:0] CH_LPAREN = 8'h28;
  localparam logic [7:0] CH_RPAREN = 8'h29;
  localparam logic [7:0] CH_STAR   = 8'h2A;
  localparam logic [7:0] CH_COMMA  = 8'h2C;
  localparam logic [7:0] CH_DOT    = 8'h2E;
  localparam logic [7:0] CH_SEMI   = 8'h3B;

  typedef struct packed {
    logic             hit;
    logic [CodeW-1:0] code;
  } kw_hit_t;

  // Word letters are packed newest in the low byte, upper bytes zero for
  // short words, so a full 64-bit compare also checks the length. The two
  // keywords with a space can never match a letter run.
  function automatic kw_hit_t kw_lookup(input logic [63:0] word);
    kw_hit_t r;
    r.hit  = 1'b1;
    r.code = KW_SELECT;
    unique case (word)
      64'h0000_5345_4C45_4354: r.code = KW_SELECT;
      64'h0000_0000_4652_4F4D: r.code = KW_FROM;
      64'h0000_0057_4845_5245: r.code = KW_WHERE;
      64'h0000_0000_0041_4E44: r.code = KW_AND;
      64'h0000_0000_0000_4F52: r.code = KW_OR;
      64'h4F52_4445_5220_4259: r.code = KW_ORDERBY;
      64'h4752_4F55_5020_4259: r.code = KW_GROUPBY;
      64'h0000_0000_0041_5343: r.code = KW_ASC;
      64'h0000_0000_4445_5343: r.code = KW_DESC;
      64'h0000_004C_494D_4954: r.code = KW_LIMIT;
      default: begin
        r.hit  = 1'b0;
        r.code = KW_SELECT;
      end
    endcase
    return r;
  endfunction

endpackage

/* hw/rtl/sts_front.sv */
// Front end: accepts text bytes, tracks the open run and builds the
// token records one byte causes (up to two). Depends on sts_pkg.
module sts_front #(
  parameter int unsigned PosWidth = sts_pkg::PosWidthDef,
  localparam int unsigned RecW    = sts_pkg::KindW + sts_pkg::CodeW + 2 * PosWidth,
  localparam int unsigned EntryW  = 2 * RecW + 1
) (
  input  logic              clk_i,
  input  logic              rst_ni,
  input  logic              accept_i,
  input  logic [7:0]        text_byte_i,
  output logic              wr_en_o,
  output logic [EntryW-1:0] wr_data_o
);
  import sts_pkg::*;

  typedef enum logic [1:0] {
    MODE_IDLE = 2'd0,
    MODE_WORD = 2'd1,
    MODE_NUM  = 2'd2,
    MODE_STR  = 2'd3
  } mode_e;

  localparam logic [PosWidth-1:0] PosMax = '1;
  localparam logic [PosWidth-1:0] PosOne = PosWidth'(1);

  mode_e               mode_q, mode_d;
  logic [PosWidth-1:0] pos_q, pos_d;
  logic [PosWidth-1:0] start_q, start_d;
  logic [PosWidth-1:0] len_q, len_d;
  logic [63:0]         word_q, word_d;

  logic                is_upper, is_digit, done;
  logic [PosWidth-1:0] len_inc, pos_inc;
  kw_hit_t             kw;

  // flush record (run closed by this byte) and new record (this byte's own)
  logic                fl_v, nw_v;
  logic [KindW-1:0]    fl_kind, nw_kind;
  logic [CodeW-1:0]    fl_code;
  logic [PosWidth-1:0] fl_len, nw_start, nw_len;
  logic [RecW-1:0]     fl_rec, nw_rec;

  assign is_upper = (text_byte_i >= 8'h41) && (text_byte_i <= 8'h5A);
  assign is_digit = (text_byte_i >= 8'h30) && (text_byte_i <= 8'h39);
  assign len_inc  = (len_q == PosMax) ? PosMax : len_q + PosOne;
  assign pos_inc  = (pos_q == PosMax) ? PosMax : pos_q + PosOne;
  assign kw       = kw_lookup(word_q);

  always_comb begin
    mode_d   = mode_q;
    start_d  = start_q;
    len_d    = len_q;
    word_d   = word_q;
    done     = 1'b0;
    fl_v     = 1'b0;
    fl_kind  = KIND_END;
    fl_code  = KW_SELECT;
    fl_len   = len_q;
    nw_v     = 1'b0;
    nw_kind  = KIND_END;
    nw_start = pos_q;
    nw_len   = PosOne;

    unique case (mode_q)
      MODE_STR: begin
        if (text_byte_i == CH_QUOTE) begin
          len_d   = len_inc;
          fl_v    = 1'b1;
          fl_kind = KIND_STRING;
          fl_len  = len_inc;
          mode_d  = MODE_IDLE;
          done    = 1'b1;
        end else if (text_byte_i == CH_NUL) begin
          fl_v    = 1'b1;
          fl_kind = KIND_UNTERM;
          mode_d  = MODE_IDLE;
        end else begin
          len_d = len_inc;
          done  = 1'b1;
        end
      end
      MODE_WORD: begin
        if (is_upper) begin
          len_d  = len_inc;
          word_d = {word_q[55:0], text_byte_i};
          done   = 1'b1;
        end else begin
          fl_v    = 1'b1;
          fl_kind = kw.hit ? KIND_KEYWORD : KIND_WORD;
          fl_code = kw.hit ? kw.code : KW_SELECT;
          mode_d  = MODE_IDLE;
        end
      end
      MODE_NUM: begin
        if (is_digit) begin
          len_d = len_inc;
          done  = 1'b1;
        end else begin
          fl_v    = 1'b1;
          fl_kind = KIND_NUMBER;
          mode_d  = MODE_IDLE;
        end
      end
      default: ;
    endcase

    if (!done) begin
      if (text_byte_i == CH_NUL) begin
        nw_v    = 1'b1;
        nw_kind = KIND_END;
        nw_len  = '0;
      end else if (text_byte_i == CH_SPACE) begin
        nw_v = 1'b0;
      end else if (is_upper) begin
        mode_d  = MODE_WORD;
        start_d = pos_q;
        len_d   = PosOne;
        word_d  = {56'd0, text_byte_i};
      end else if (is_digit) begin
        mode_d  = MODE_NUM;
        start_d = pos_q;
        len_d   = PosOne;
      end else if (text_byte_i == CH_QUOTE) begin
        mode_d  = MODE_STR;
        start_d = pos_q;
        len_d   = PosOne;
      end else begin
        nw_v = 1'b1;
        case (text_byte_i)
          CH_COMMA:  nw_kind = KIND_COMMA;
          CH_SEMI:   nw_kind = KIND_SEMI;
          CH_LPAREN: nw_kind = KIND_LPAREN;
          CH_RPAREN: nw_kind = KIND_RPAREN;
          CH_STAR:   nw_kind = KIND_STAR;
          CH_DOT:    nw_kind = KIND_DOT;
          default:   nw_kind = KIND_UNKNOWN;
        endcase
      end
    end

    // end of text: back to the reset state, next byte is offset 0
    if (text_byte_i == CH_NUL) begin
      mode_d  = MODE_IDLE;
      pos_d   = '0;
      start_d = '0;
      len_d   = '0;
      word_d  = '0;
    end else begin
      pos_d = pos_inc;
    end
  end

  assign fl_rec = {fl_kind, fl_code, start_q, fl_len};
  assign nw_rec = {nw_kind, KW_SELECT, nw_start, nw_len};

  // entry: {second valid, first record, second record}
  assign wr_en_o   = accept_i && (fl_v || nw_v);
  assign wr_data_o = fl_v ? {nw_v, fl_rec, nw_rec} : {1'b0, nw_rec, nw_rec};

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      mode_q  <= MODE_IDLE;
      pos_q   <= '0;
      start_q <= '0;
      len_q   <= '0;
      word_q  <= '0;
    end else if (accept_i) begin
      mode_q  <= mode_d;
      pos_q   <= pos_d;
      start_q <= start_d;
      len_q   <= len_d;
      word_q  <= word_d;
    end
  end

endmodule

/* hw/rtl/sts_queue.sv */
// Short queue between the scanner front end and the result back end.
// Depth from sts_pkg::QueueDepth; depends on sts_pkg.
module sts_queue #(
  parameter int unsigned Width = 8
) (
  input  logic             clk_i,
  input  logic             rst_ni,
  input  logic             wr_en_i,
  input  logic [Width-1:0] wr_data_i,
  output logic             full_o,
  input  logic             rd_en_i,
  output logic [Width-1:0] rd_data_o,
  output logic             empty_o
);
  import sts_pkg::*;

  localparam int unsigned PtrW = (QueueDepth > 1) ? $clog2(QueueDepth) : 1;
  localparam int unsigned CntW = $clog2(QueueDepth + 1);
  localparam logic [CntW-1:0] CntFull = CntW'(QueueDepth);
  localparam logic [PtrW-1:0] PtrLast = PtrW'(QueueDepth - 1);

  logic [Width-1:0] mem_q [QueueDepth];
  logic [PtrW-1:0]  wr_ptr_q, rd_ptr_q;
  logic [CntW-1:0]  cnt_q;
  logic             do_wr, do_rd;

  assign full_o    = (cnt_q == CntFull);
  assign empty_o   = (cnt_q == '0);
  assign do_wr     = wr_en_i && !full_o;
  assign do_rd     = rd_en_i && !empty_o;
  assign rd_data_o = mem_q[rd_ptr_q];

  always_ff @(posedge clk_i) begin
    if (do_wr) begin
      mem_q[wr_ptr_q] <= wr_data_i;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      wr_ptr_q <= '0;
      rd_ptr_q <= '0;
      cnt_q    <= '0;
    end else begin
      if (do_wr) begin
        wr_ptr_q <= (wr_ptr_q == PtrLast) ? '0 : wr_ptr_q + PtrW'(1);
      end
      if (do_rd) begin
        rd_ptr_q <= (rd_ptr_q == PtrLast) ? '0 : rd_ptr_q + PtrW'(1);
      end
      if (do_wr && !do_rd) begin
        cnt_q <= cnt_q + CntW'(1);
      end else if (do_rd && !do_wr) begin
        cnt_q <= cnt_q - CntW'(1);
      end
    end
  end

endmodule

/* hw/rtl/sts_back.sv */
// Back end: takes queue entries of one or two token records and hands
// them out one per pop from an output register. Depends on sts_pkg.
module sts_back #(
  parameter int unsigned PosWidth = sts_pkg::PosWidthDef,
  localparam int unsigned RecW    = sts_pkg::KindW + sts_pkg::CodeW + 2 * PosWidth,
  localparam int unsigned EntryW  = 2 * RecW + 1
) (
  input  logic                       clk_i,
  input  logic                       rst_ni,
  input  logic                       q_empty_i,
  input  logic [EntryW-1:0]          q_data_i,
  output logic                       q_rd_o,
  input  logic                       pop_i,
  output logic                       empty_o,
  output logic [sts_pkg::KindW-1:0]  token_kind_o,
  output logic [sts_pkg::CodeW-1:0]  keyword_code_o,
  output logic [sts_pkg::FieldW-1:0] token_start_o,
  output logic [sts_pkg::FieldW-1:0] token_length_o,
  output logic                       last_of_run_o
);
  import sts_pkg::*;

  logic              valid_q;
  logic              sel_q;    // showing the second record of the entry
  logic [EntryW-1:0] ent_q;
  logic              two;
  logic [RecW-1:0]   rec;
  logic              take, finish, load;
  logic [31:0]       start_ext, len_ext;

  assign two    = ent_q[EntryW-1];
  assign rec    = sel_q ? ent_q[RecW-1:0] : ent_q[2*RecW-1:RecW];
  assign take   = pop_i && valid_q;
  assign finish = take && (!two || sel_q);
  assign load   = (!valid_q || finish) && !q_empty_i;
  assign q_rd_o = load;

  assign start_ext      = 32'(rec[2*PosWidth-1:PosWidth]);
  assign len_ext        = 32'(rec[PosWidth-1:0]);
  assign empty_o        = !valid_q;
  assign token_kind_o   = rec[RecW-1 -: KindW];
  assign keyword_code_o = rec[RecW-KindW-1 -: CodeW];
  assign token_start_o  = start_ext[FieldW-1:0];
  assign token_length_o = len_ext[FieldW-1:0];
  assign last_of_run_o  = !two || sel_q;

  always_ff @(posedge clk_i) begin
    if (load) begin
      ent_q <= q_data_i;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      valid_q <= 1'b0;
      sel_q   <= 1'b0;
    end else if (load) begin
      valid_q <= 1'b1;
      sel_q   <= 1'b0;
    end else if (finish) begin
      valid_q <= 1'b0;
      sel_q   <= 1'b0;
    end else if (take) begin
      sel_q <= 1'b1;
    end
  end

endmodule

/* hw/rtl/sql_token_scanner_unit.sv */
// SQL token scanner: one text byte per item in, token records out.
// Input side is a queue: drive text_byte_i with push; the byte is taken at
// a clock edge with push high and full low. A zero byte ends the text,
// flushes any open word, number or string and yields an end token; the
// next byte starts a new text at offset 0.
// Result side is a queue too: while empty is low the oldest token record
// is on the result ports; pop takes it. last_of_run_o marks the last record
// caused by one byte (a byte causes zero, one or two records).
// Throughput: one byte per cycle in while full is low, one record per cycle
// out while pop is high and records wait. A record goes through the queue
// (written as its byte is taken) and the output register (loaded once the
// one ahead is popped). The front end's run state advances once per byte.
// When the receiver stalls, records collect in a four-entry queue plus the
// output register; once that queue fills, full rises and input stops.
// Reset clears the run state and both queues; no record is pending after.
// Depends on sts_pkg, sts_front, sts_queue, sts_back.
module sql_token_scanner_unit #(
  parameter int unsigned PosWidth = sts_pkg::PosWidthDef
) (
  input  logic                       clk_i,
  input  logic                       rst_ni,
  input  logic                       push,
  output logic                       full,
  input  logic [7:0]                 text_byte_i,
  output logic                       empty,
  input  logic                       pop,
  output logic [sts_pkg::KindW-1:0]  token_kind_o,
  output logic [sts_pkg::CodeW-1:0]  keyword_code_o,
  output logic [sts_pkg::FieldW-1:0] token_start_o,
  output logic [sts_pkg::FieldW-1:0] token_length_o,
  output logic                       last_of_run_o
);
  import sts_pkg::*;

  localparam int unsigned RecW   = KindW + CodeW + 2 * PosWidth;
  localparam int unsigned EntryW = 2 * RecW + 1;

  logic              accept;
  logic              wr_en, q_rd, q_empty;
  logic [EntryW-1:0] wr_data, rd_data;

  assign accept = push && !full;

  sts_front #(.PosWidth(PosWidth)) u_front (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .accept_i    (accept),
    .text_byte_i (text_byte_i),
    .wr_en_o     (wr_en),
    .wr_data_o   (wr_data)
  );

  sts_queue #(.Width(EntryW)) u_queue (
    .clk_i     (clk_i),
    .rst_ni    (rst_ni),
    .wr_en_i   (wr_en),
    .wr_data_i (wr_data),
    .full_o    (full),
    .rd_en_i   (q_rd),
    .rd_data_o (rd_data),
    .empty_o   (q_empty)
  );

  sts_back #(.PosWidth(PosWidth)) u_back (
    .clk_i          (clk_i),
    .rst_ni         (rst_ni),
    .q_empty_i      (q_empty),
    .q_data_i       (rd_data),
    .q_rd_o         (q_rd),
    .pop_i          (pop),
    .empty_o        (empty),
    .token_kind_o   (token_kind_o),
    .keyword_code_o (keyword_code_o),
    .token_start_o  (token_start_o),
    .token_length_o (token_length_o),
    .last_of_run_o  (last_of_run_o)
  );

endmodule
